[src/crc16_frame_deframer_core_assert.svh]
// ---------------------------------------------------------------------------
// assertion macros for the crc16 frame deframer
// ---------------------------------------------------------------------------
`ifndef CRC16_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define CRC16_FRAME_DEFRAMER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every edge out of reset
`define C16DF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define C16DF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define C16DF_ASSERT(lbl, clk, rst_n, prop, msg)
`define C16DF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[src/c16df_pkg.sv]
// ---------------------------------------------------------------------------
// c16df_pkg
// types and constants shared by the deframer modules, and the crc step used by the parser
// ---------------------------------------------------------------------------
`default_nettype none

package c16df_pkg;

  typedef enum logic [3:0] {
    PH_HDR0    = 4'd0,
    PH_HDR1    = 4'd1,
    PH_LEN0    = 4'd2,
    PH_LEN1    = 4'd3,
    PH_TYPE    = 4'd4,
    PH_PAYLOAD = 4'd5,
    PH_CRC0    = 4'd6,
    PH_CRC1    = 4'd7,
    PH_FTR0    = 4'd8,
    PH_FTR1    = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    ABORT_NONE   = 2'd0,
    ABORT_LENGTH = 2'd1,
    ABORT_CRC    = 2'd2,
    ABORT_FOOTER = 2'd3
  } abort_e;

  localparam int unsigned PaddrWidth = 4;

  typedef enum logic [1:0] {
    REG_HEADER  = 2'd0,
    REG_FOOTER  = 2'd1,
    REG_MAX_PAY = 2'd2
  } reg_idx_e;

  localparam logic [15:0] CrcPoly     = 16'h1021;
  localparam logic [15:0] LenOverhead = 16'd3;

  typedef struct packed {
    logic [15:0] header_word;
    logic [15:0] footer_word;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        frame_done;
    abort_e      abort_reason;
    logic [7:0]  frame_type;
    logic [15:0] payload_length;
  } result_t;

  // one byte of crc-16, msb first, unrolled over the eight bit steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/crc16_frame_deframer_core.sv]
// the input register loads an accepted word and the result register then takes its result word;
//   res_valid_o rises when the result register is loaded, which a result stall can hold back
// throughput: one word per cycle while the result register is not stalled by res_ready_i; the
//   parse state and crc are updated by the unrolled crc-16 xor network after the input register
// reset: rst_ni clears the configuration registers to zero, the parser to header hunting and
//   both word registers to empty
// ---------------------------------------------------------------------------
// crc16_frame_deframer_core
// byte-serial deframer for length-prefixed frames with a crc-16 check
// ---------------------------------------------------------------------------
`default_nettype none

module crc16_frame_deframer_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // apb configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [c16df_pkg::PaddrWidth-1:0]  paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  // received byte channel
  input  wire logic                              rx_valid_i,
  output logic                                   rx_ready_o,
  input  wire logic [7:0]                        rx_byte_i,
  // result channel
  output logic                                   res_valid_o,
  input  wire logic                              res_ready_i,
  output logic                                   payload_valid_o,
  output logic [7:0]                             payload_byte_o,
  output logic [15:0]                            payload_index_o,
  output logic                                   frame_done_o,
  output logic [1:0]                             abort_reason_o,
  output logic [7:0]                             frame_type_o,
  output logic [15:0]                            payload_length_o
);
  import c16df_pkg::*;

  // configuration registers
  cfg_t cfg;

  c16df_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register: holds the next word to be parsed
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;

  // result register: holds the finished word until the sink takes it
  logic    res_valid_q, res_valid_d;
  result_t res_q;
  result_t res_step;

  logic rx_fire;
  logic advance;

  // a word moves on when the result register is empty or being drained
  assign advance    = in_valid_q && (!res_valid_q || res_ready_i);
  // input side stays open while the held word is moving on
  assign rx_ready_o = !in_valid_q || advance;
  assign rx_fire    = rx_valid_i && rx_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (rx_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (advance) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  // parse step: the state only moves when the word is committed to the result register
  c16df_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .res_o  (res_step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance) begin
      res_q <= res_step;
    end
  end

  assign res_valid_o      = res_valid_q;
  assign payload_valid_o  = res_q.payload_valid;
  assign payload_byte_o   = res_q.payload_byte;
  assign payload_index_o  = res_q.payload_index;
  assign frame_done_o     = res_q.frame_done;
  assign abort_reason_o   = 2'(res_q.abort_reason);
  assign frame_type_o     = res_q.frame_type;
  assign payload_length_o = res_q.payload_length;

  // checks on the datapath and the stage handover
`include "crc16_frame_deframer_core_assert.svh"

  `C16DF_ASSERT_NEVER(a_done_and_abort, clk_i, rst_ni,
    res_valid_q && res_q.frame_done && (res_q.abort_reason != ABORT_NONE),
    "frame done together with an abort")

  `C16DF_ASSERT_NEVER(a_payload_and_abort, clk_i, rst_ni,
    res_valid_q && res_q.payload_valid && (res_q.abort_reason != ABORT_NONE),
    "payload word flagged as abort")

  `C16DF_ASSERT(a_index_in_range, clk_i, rst_ni,
    (res_valid_q && res_q.payload_valid) |-> (res_q.payload_index < res_q.payload_length),
    "payload index beyond frame length")

  `C16DF_ASSERT(a_stall_holds_input, clk_i, rst_ni,
    (in_valid_q && res_valid_q && !res_ready_i) |=> (in_valid_q && $stable(in_byte_q)),
    "held word lost during result stall")

endmodule

`default_nettype wire

[src/c16df_apb_regs.sv]
// ---------------------------------------------------------------------------
// c16df_apb_regs
// apb register bank: header word, footer word and payload capacity
// ---------------------------------------------------------------------------
`default_nettype none

module c16df_apb_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [c16df_pkg::PaddrWidth-1:0]  paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  output c16df_pkg::cfg_t                        cfg_o
);
  import c16df_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_HEADER:  cfg_d.header_word = pwdata[15:0];
        REG_FOOTER:  cfg_d.footer_word = pwdata[15:0];
        REG_MAX_PAY: cfg_d.max_payload = pwdata[15:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HEADER:  prdata = {16'h0000, cfg_q.header_word};
      REG_FOOTER:  prdata = {16'h0000, cfg_q.footer_word};
      REG_MAX_PAY: prdata = {16'h0000, cfg_q.max_payload};
      default:     prdata = 32'h0000_0000;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

[src/c16df_parser.sv]
// ---------------------------------------------------------------------------
// c16df_parser
// frame parse state and the per-word step: phase, length, position, crc
// ---------------------------------------------------------------------------
`default_nettype none

module c16df_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [7:0]         byte_i,
  input  wire c16df_pkg::cfg_t    cfg_i,
  output c16df_pkg::result_t      res_o
);
  import c16df_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rcrc_q, rcrc_d;
  logic [7:0]  kind_q, kind_d;

  logic [15:0] crc_step;
  logic [15:0] len_full;
  logic [15:0] pay_cnt;
  logic [15:0] pos_inc;
  logic [15:0] rcrc_full;

  assign crc_step  = crc16_byte(crc_q, byte_i);
  assign len_full  = {len_q[15:8], byte_i};
  assign pay_cnt   = len_full - LenOverhead;
  assign pos_inc   = pos_q + 16'd1;
  assign rcrc_full = {rcrc_q[15:8], byte_i};

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    rcrc_d  = rcrc_q;
    kind_d  = kind_q;
    res_o   = '0;

    unique case (phase_q)
      PH_HDR0: begin
        if (byte_i == cfg_i.header_word[15:8]) phase_d = PH_HDR1;
      end
      PH_HDR1: begin
        // a wrong low byte that matches the high byte restarts the header
        if (byte_i == cfg_i.header_word[7:0]) begin
          phase_d = PH_LEN0;
        end else if (byte_i == cfg_i.header_word[15:8]) begin
          phase_d = PH_HDR1;
        end else begin
          phase_d = PH_HDR0;
        end
      end
      PH_LEN0: begin
        len_d   = {byte_i, 8'h00};
        crc_d   = crc16_byte(16'h0000, byte_i);
        phase_d = PH_LEN1;
      end
      PH_LEN1: begin
        if ((len_full < LenOverhead) || (pay_cnt > cfg_i.max_payload)) begin
          phase_d            = PH_HDR0;
          len_d              = '0;
          pos_d              = '0;
          crc_d              = '0;
          rcrc_d             = '0;
          kind_d             = '0;
          res_o.abort_reason = ABORT_LENGTH;
        end else begin
          len_d                = pay_cnt;
          crc_d                = crc_step;
          pos_d                = '0;
          phase_d              = PH_TYPE;
          res_o.payload_length = pay_cnt;
        end
      end
      PH_TYPE: begin
        kind_d               = byte_i;
        crc_d                = crc_step;
        phase_d              = (len_q != 16'd0) ? PH_PAYLOAD : PH_CRC0;
        res_o.frame_type     = byte_i;
        res_o.payload_length = len_q;
      end
      PH_PAYLOAD: begin
        res_o.payload_valid  = 1'b1;
        res_o.payload_byte   = byte_i;
        res_o.payload_index  = pos_q;
        pos_d                = pos_inc;
        crc_d                = crc_step;
        if (pos_inc == len_q) phase_d = PH_CRC0;
        res_o.frame_type     = kind_q;
        res_o.payload_length = len_q;
      end
      PH_CRC0: begin
        rcrc_d               = {byte_i, 8'h00};
        phase_d              = PH_CRC1;
        res_o.frame_type     = kind_q;
        res_o.payload_length = len_q;
      end
      PH_CRC1: begin
        res_o.frame_type     = kind_q;
        res_o.payload_length = len_q;
        if (rcrc_full != crc_q) begin
          phase_d            = PH_HDR0;
          len_d              = '0;
          pos_d              = '0;
          crc_d              = '0;
          rcrc_d             = '0;
          kind_d             = '0;
          res_o.abort_reason = ABORT_CRC;
        end else begin
          rcrc_d  = rcrc_full;
          phase_d = PH_FTR0;
        end
      end
      PH_FTR0: begin
        res_o.frame_type     = kind_q;
        res_o.payload_length = len_q;
        if (byte_i == cfg_i.footer_word[15:8]) begin
          phase_d = PH_FTR1;
        end else begin
          phase_d            = PH_HDR0;
          res_o.abort_reason = ABORT_FOOTER;
        end
      end
      PH_FTR1: begin
        res_o.frame_type     = kind_q;
        res_o.payload_length = len_q;
        phase_d              = PH_HDR0;
        if (byte_i == cfg_i.footer_word[7:0]) begin
          res_o.frame_done = 1'b1;
        end else begin
          res_o.abort_reason = ABORT_FOOTER;
        end
      end
      default: begin
        // meaningless phase code: drop the word and clear everything
        phase_d = PH_HDR0;
        len_d   = '0;
        pos_d   = '0;
        crc_d   = '0;
        rcrc_d  = '0;
        kind_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      len_q   <= '0;
      pos_q   <= '0;
      crc_q   <= '0;
      rcrc_q  <= '0;
      kind_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      rcrc_q  <= rcrc_d;
      kind_q  <= kind_d;
    end
  end

endmodule

`default_nettype wire
